// File: rtl/tpl_pkg.sv
// shared types, codes and reset constants of the trade position lifecycle block
`default_nettype none

package tpl_pkg;

   // fixed field widths
   localparam int SPREAD_BITS   = 24;
   localparam int CONTRACT_BITS = 16;
   localparam int TIMEOUT_BITS  = 8;
   localparam int LIMIT_BITS    = 16;
   localparam int CSR_DATA_BITS = 24;
   localparam int CSR_IDX_BITS  = 2;

   // default widths of the price and id fields
   localparam int PRICE_BITS_DEF = 24;
   localparam int ID_BITS_DEF    = 16;

   // register reset values
   localparam logic [SPREAD_BITS-1:0]   SPREAD_CAP_RST  = 24'd10000000;
   localparam logic [CONTRACT_BITS-1:0] CONTRACTS_RST   = 16'd1;
   localparam logic [TIMEOUT_BITS-1:0]  TIMEOUT_RST     = 8'd60;

   // position modes
   typedef enum logic [2:0] {
      MODE_IDLE      = 3'd0,
      MODE_TRY_LONG  = 3'd1,
      MODE_TRY_SHORT = 3'd2,
      MODE_LONG      = 3'd3,
      MODE_SHORT     = 3'd4,
      MODE_CLS_LONG  = 3'd5,
      MODE_CLS_SHORT = 3'd6
   } mode_type;

   // event kinds
   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_OPEN   = 2'd1,
      OP_CLOSE  = 2'd2,
      OP_SYNC   = 2'd3
   } op_type;

   // order requests
   typedef enum logic [1:0] {
      ACT_NONE       = 2'd0,
      ACT_OPEN_LONG  = 2'd1,
      ACT_OPEN_SHORT = 2'd2,
      ACT_CLOSE      = 2'd3
   } action_type;

   // strategy advice codes, the undefined code counts as no advice
   localparam logic [1:0] ADV_NONE  = 2'd0;
   localparam logic [1:0] ADV_LONG  = 2'd1;
   localparam logic [1:0] ADV_SHORT = 2'd2;
   localparam logic [1:0] ADV_UNDEF = 2'd3;

   // register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SPREAD_CAP = 2'd0,
      CSR_CONTRACTS  = 2'd1,
      CSR_TIMEOUT    = 2'd2,
      CSR_UNUSED     = 2'd3
   } csr_reg_type;

   // configuration bundle
   typedef struct packed {
      logic [SPREAD_BITS-1:0]   spread_cap;
      logic [CONTRACT_BITS-1:0] contract_count;
      logic [TIMEOUT_BITS-1:0]  pending_timeout;
   } cfg_type;

endpackage

`default_nettype wire

// File: rtl/tpl_cfg_regs.sv
// configuration register file with its write channel
`default_nettype none

module tpl_cfg_regs (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [tpl_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [tpl_pkg::CSR_DATA_BITS-1:0] csr_data,
   output tpl_pkg::cfg_type                       cfg
);

   tpl_pkg::cfg_type cfg_ff;
   tpl_pkg::cfg_type cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (tpl_pkg::csr_reg_type'(csr_index))
            tpl_pkg::CSR_SPREAD_CAP: begin
               cfg_in.spread_cap = csr_data[tpl_pkg::SPREAD_BITS-1:0];
            end
            tpl_pkg::CSR_CONTRACTS: begin
               cfg_in.contract_count = csr_data[tpl_pkg::CONTRACT_BITS-1:0];
            end
            tpl_pkg::CSR_TIMEOUT: begin
               cfg_in.pending_timeout = csr_data[tpl_pkg::TIMEOUT_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spread_cap      <= tpl_pkg::SPREAD_CAP_RST;
         cfg_ff.contract_count  <= tpl_pkg::CONTRACTS_RST;
         cfg_ff.pending_timeout <= tpl_pkg::TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/trade_position_lifecycle_fsm.sv
// top level: trade position lifecycle controller
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+--------------------------------------
//  req_    | in  | req_tvalid / req_tready  | tuser op, tdata event fields
//  rsp_    | out | rsp_tvalid / rsp_tready  | tdata action, ids, mode, flags
//  csr_    | in  | csr_valid / csr_ready    | csr_index, csr_data
//
// one item per cycle sustained while results are taken; an accepted item is held in the
// input register, then the mode update and result register follow in one pass
// reset clears the mode, position state and id counter and loads register defaults
// a stalled result holds in the output register; one more item can wait in the
// input register, after which req_tready stays low until the result is taken
`default_nettype none

module trade_position_lifecycle_fsm #(
   parameter int PRICE_BITS = tpl_pkg::PRICE_BITS_DEF,
   parameter int ID_BITS    = tpl_pkg::ID_BITS_DEF,
   localparam int IN_BITS   = 3 * PRICE_BITS + ID_BITS + 20,
   localparam int IN_BYTES  = (IN_BITS + 7) / 8,
   localparam int OUT_BITS  = ID_BITS + 23,
   localparam int OUT_BYTES = (OUT_BITS + 7) / 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input items
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // ask, bid, advice, advice limit, event id, event ok, event price,
   // event is-long
   input  wire logic [8*IN_BYTES-1:0]             req_tdata,
   // op
   input  wire logic [1:0]                        req_tuser,
   // result items
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // action, action_id, action_contracts, mode_now, sync_error, ignored
   output logic [8*OUT_BYTES-1:0]                 rsp_tdata,
   // configuration writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [tpl_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [tpl_pkg::CSR_DATA_BITS-1:0] csr_data
);

   localparam int P  = PRICE_BITS;
   localparam int I  = ID_BITS;
   localparam int LB = tpl_pkg::LIMIT_BITS;
   localparam int SB = tpl_pkg::SPREAD_BITS;
   localparam int CB = tpl_pkg::CONTRACT_BITS;
   localparam int TB = tpl_pkg::TIMEOUT_BITS;
   // compare widths
   localparam int SCW = (P > SB) ? P : SB;
   localparam int LCW = (P > LB) ? P : LB;
   // input field offsets
   localparam int O_ASK   = 0;
   localparam int O_BID   = P;
   localparam int O_ADV   = 2 * P;
   localparam int O_LIM   = 2 * P + 2;
   localparam int O_EID   = 2 * P + 2 + LB;
   localparam int O_OK    = O_EID + I;
   localparam int O_PRICE = O_OK + 1;
   localparam int O_LONG  = O_PRICE + P;

   tpl_pkg::cfg_type cfg;

   // configuration registers
   tpl_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // input register
   logic                 in_vld_ff, in_vld_in;
   tpl_pkg::op_type      in_op_ff;
   logic [P-1:0]         in_ask_ff, in_bid_ff, in_price_ff;
   logic [1:0]           in_adv_ff;
   logic [LB-1:0]        in_lim_ff;
   logic [I-1:0]         in_eid_ff;
   logic                 in_ok_ff, in_long_ff;

   // result register
   logic                 out_vld_ff, out_vld_in;
   logic [OUT_BITS-1:0]  out_data_ff, out_data_in;

   // position state
   tpl_pkg::mode_type    mode_ff, mode_in;
   logic [P-1:0]         entry_ff, entry_in;
   logic [LB-1:0]        limit_ff, limit_in;
   logic                 retry_ff, retry_in;
   logic [I-1:0]         cur_id_ff, cur_id_in;
   logic                 id_pres_ff, id_pres_in;
   logic                 conf_ff, conf_in;
   logic [TB-1:0]        wait_ff, wait_in;
   logic [I-1:0]         next_id_ff, next_id_in;

   logic                 advance;
   logic                 req_take;

   // handshakes
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(8*OUT_BYTES-OUT_BITS){1'b0}}, out_data_ff};

   // input register control
   always_comb begin
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   // input payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff    <= tpl_pkg::op_type'(req_tuser);
         in_ask_ff   <= req_tdata[O_ASK +: P];
         in_bid_ff   <= req_tdata[O_BID +: P];
         in_adv_ff   <= req_tdata[O_ADV +: 2];
         in_lim_ff   <= req_tdata[O_LIM +: LB];
         in_eid_ff   <= req_tdata[O_EID +: I];
         in_ok_ff    <= req_tdata[O_OK];
         in_price_ff <= req_tdata[O_PRICE +: P];
         in_long_ff  <= req_tdata[O_LONG];
      end
   end

   // datapath terms for a held position
   logic                 held_long;
   logic                 spread_over;
   logic [P-1:0]         spread;
   logic [P-1:0]         yield_px;
   logic [P-1:0]         yield_mag;
   logic                 below_limit;
   logic                 renew;
   logic [TB:0]          wait_next;
   logic                 wait_over;
   logic                 id_match;
   logic                 sync_long;

   assign held_long   = (mode_ff == tpl_pkg::MODE_LONG);
   assign spread      = in_ask_ff - in_bid_ff;
   assign spread_over = (in_ask_ff > in_bid_ff) &&
                        (SCW'(spread) > SCW'(cfg.spread_cap));
   assign yield_px    = held_long ? in_bid_ff : in_ask_ff;
   assign yield_mag   = (yield_px >= entry_ff) ? (yield_px - entry_ff)
                                               : (entry_ff - yield_px);
   assign below_limit = LCW'(yield_mag) < LCW'(limit_ff);
   assign renew       = in_adv_ff == (held_long ? tpl_pkg::ADV_LONG : tpl_pkg::ADV_SHORT);
   assign wait_next   = {1'b0, wait_ff} + {{TB{1'b0}}, 1'b1};
   assign wait_over   = wait_next > {1'b0, cfg.pending_timeout};
   assign id_match    = id_pres_ff && (in_eid_ff == cur_id_ff);
   assign sync_long   = (mode_ff == tpl_pkg::MODE_LONG) ||
                        (mode_ff == tpl_pkg::MODE_CLS_LONG) ||
                        (mode_ff == tpl_pkg::MODE_TRY_LONG);

   // result fields
   tpl_pkg::action_type  act;
   logic [I-1:0]         act_id;
   logic [CB-1:0]        act_cnt;
   logic                 serr;
   logic                 ign;

   // mode update and result for one item
   always_comb begin
      mode_in    = mode_ff;
      entry_in   = entry_ff;
      limit_in   = limit_ff;
      retry_in   = retry_ff;
      cur_id_in  = cur_id_ff;
      id_pres_in = id_pres_ff;
      conf_in    = conf_ff;
      wait_in    = wait_ff;
      next_id_in = next_id_ff;
      act        = tpl_pkg::ACT_NONE;
      act_id     = '0;
      act_cnt    = '0;
      serr       = 1'b0;
      ign        = 1'b0;
      if (advance) begin
         unique case (in_op_ff)
            tpl_pkg::OP_TICK: begin
               // an unconfirmed position is dropped before the tick
               if (!conf_ff) begin
                  mode_in    = tpl_pkg::MODE_IDLE;
                  entry_in   = '0;
                  limit_in   = '0;
                  retry_in   = 1'b0;
                  id_pres_in = 1'b0;
                  cur_id_in  = '0;
                  conf_in    = 1'b1;
               end
               unique case (mode_in)
                  tpl_pkg::MODE_LONG, tpl_pkg::MODE_SHORT: begin
                     if (!spread_over) begin
                        if (retry_ff) begin
                           mode_in = held_long ? tpl_pkg::MODE_CLS_LONG
                                               : tpl_pkg::MODE_CLS_SHORT;
                           act     = tpl_pkg::ACT_CLOSE;
                        end else if (!below_limit) begin
                           if (renew) begin
                              entry_in = held_long ? in_ask_ff : in_bid_ff;
                              limit_in = in_lim_ff;
                           end else begin
                              mode_in = held_long ? tpl_pkg::MODE_CLS_LONG
                                                  : tpl_pkg::MODE_CLS_SHORT;
                              act     = tpl_pkg::ACT_CLOSE;
                           end
                        end
                     end
                     if (act == tpl_pkg::ACT_CLOSE) begin
                        act_id = cur_id_ff;
                     end
                  end
                  tpl_pkg::MODE_TRY_LONG, tpl_pkg::MODE_TRY_SHORT,
                  tpl_pkg::MODE_CLS_LONG, tpl_pkg::MODE_CLS_SHORT: begin
                     // pending timeout
                     if (wait_over) begin
                        wait_in  = '0;
                        retry_in = 1'b0;
                        if (mode_ff == tpl_pkg::MODE_TRY_LONG ||
                            mode_ff == tpl_pkg::MODE_TRY_SHORT) begin
                           mode_in    = tpl_pkg::MODE_IDLE;
                           entry_in   = '0;
                           id_pres_in = 1'b0;
                           cur_id_in  = '0;
                        end else if (mode_ff == tpl_pkg::MODE_CLS_LONG) begin
                           mode_in = tpl_pkg::MODE_LONG;
                        end else begin
                           mode_in = tpl_pkg::MODE_SHORT;
                        end
                     end else begin
                        wait_in = wait_next[TB-1:0];
                     end
                  end
                  default: begin
                     // idle: open on advice
                     if (in_adv_ff == tpl_pkg::ADV_LONG || in_adv_ff == tpl_pkg::ADV_SHORT) begin
                        mode_in    = (in_adv_ff == tpl_pkg::ADV_LONG) ? tpl_pkg::MODE_TRY_LONG
                                                                      : tpl_pkg::MODE_TRY_SHORT;
                        entry_in   = (in_adv_ff == tpl_pkg::ADV_LONG) ? in_ask_ff : in_bid_ff;
                        cur_id_in  = next_id_ff;
                        id_pres_in = 1'b1;
                        next_id_in = next_id_ff + {{(I-1){1'b0}}, 1'b1};
                        retry_in   = 1'b0;
                        limit_in   = in_lim_ff;
                        act        = (in_adv_ff == tpl_pkg::ADV_LONG) ? tpl_pkg::ACT_OPEN_LONG
                                                                      : tpl_pkg::ACT_OPEN_SHORT;
                        act_id     = next_id_ff;
                        act_cnt    = cfg.contract_count;
                     end
                  end
               endcase
            end
            tpl_pkg::OP_OPEN: begin
               if ((mode_ff != tpl_pkg::MODE_TRY_LONG && mode_ff != tpl_pkg::MODE_TRY_SHORT)
                   || !id_match) begin
                  ign = 1'b1;
               end else if (in_ok_ff) begin
                  mode_in  = (mode_ff == tpl_pkg::MODE_TRY_LONG) ? tpl_pkg::MODE_LONG
                                                                 : tpl_pkg::MODE_SHORT;
                  entry_in = in_price_ff;
               end else begin
                  mode_in    = tpl_pkg::MODE_IDLE;
                  entry_in   = '0;
                  limit_in   = '0;
                  id_pres_in = 1'b0;
                  cur_id_in  = '0;
               end
            end
            tpl_pkg::OP_CLOSE: begin
               if ((mode_ff != tpl_pkg::MODE_CLS_LONG && mode_ff != tpl_pkg::MODE_CLS_SHORT)
                   || !id_match) begin
                  ign = 1'b1;
               end else if (in_ok_ff) begin
                  mode_in    = tpl_pkg::MODE_IDLE;
                  entry_in   = '0;
                  limit_in   = '0;
                  retry_in   = 1'b0;
                  id_pres_in = 1'b0;
                  cur_id_in  = '0;
               end else begin
                  mode_in  = (mode_ff == tpl_pkg::MODE_CLS_LONG) ? tpl_pkg::MODE_LONG
                                                                 : tpl_pkg::MODE_SHORT;
                  retry_in = 1'b1;
               end
            end
            default: begin
               // sync report, only while unconfirmed
               if (!conf_ff) begin
                  if (!id_pres_ff) begin
                     mode_in  = tpl_pkg::MODE_IDLE;
                     entry_in = '0;
                     limit_in = '0;
                     retry_in = 1'b0;
                     cur_id_in = '0;
                     conf_in  = 1'b1;
                  end else if (in_eid_ff != cur_id_ff) begin
                     ign = 1'b1;
                  end else if (mode_ff == tpl_pkg::MODE_IDLE) begin
                     conf_in = 1'b1;
                  end else if (sync_long != in_long_ff) begin
                     serr = 1'b1;
                  end else begin
                     mode_in  = sync_long ? tpl_pkg::MODE_LONG : tpl_pkg::MODE_SHORT;
                     entry_in = in_price_ff;
                     retry_in = 1'b0;
                     conf_in  = 1'b1;
                  end
               end
            end
         endcase
      end
   end

   // result register control
   always_comb begin
      out_data_in = {ign, serr, mode_in, act_cnt, act_id, act};
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // control and position state
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         mode_ff    <= tpl_pkg::MODE_IDLE;
         entry_ff   <= '0;
         limit_ff   <= '0;
         retry_ff   <= 1'b0;
         cur_id_ff  <= '0;
         id_pres_ff <= 1'b0;
         conf_ff    <= 1'b0;
         wait_ff    <= '0;
         next_id_ff <= '0;
      end else begin
         out_vld_ff <= out_vld_in;
         mode_ff    <= mode_in;
         entry_ff   <= entry_in;
         limit_ff   <= limit_in;
         retry_ff   <= retry_in;
         cur_id_ff  <= cur_id_in;
         id_pres_ff <= id_pres_in;
         conf_ff    <= conf_in;
         wait_ff    <= wait_in;
         next_id_ff <= next_id_in;
      end
   end

   // checks
   a_open_goes_pending: assert property (@(posedge clock) disable iff (reset)
      advance && act == tpl_pkg::ACT_OPEN_LONG |=> mode_ff == tpl_pkg::MODE_TRY_LONG)
      else $error("open long did not enter pending long");

   a_close_goes_pending: assert property (@(posedge clock) disable iff (reset)
      advance && act == tpl_pkg::ACT_CLOSE |=>
      (mode_ff == tpl_pkg::MODE_CLS_LONG || mode_ff == tpl_pkg::MODE_CLS_SHORT))
      else $error("close request without pending close mode");

   a_no_id_zero: assert property (@(posedge clock) disable iff (reset)
      !id_pres_ff |-> cur_id_ff == '0)
      else $error("stale position id without id present");

   a_confirm_sticks: assert property (@(posedge clock) disable iff (reset)
      conf_ff |=> conf_ff)
      else $error("confirmed flag cleared");

endmodule

`default_nettype wire

// File: dv/trade_position_lifecycle_fsm_tb.sv
// self-checking testbench of the trade position lifecycle block: predicts every result item
`timescale 1ns / 100ps

module trade_position_lifecycle_fsm_tb;

   localparam int STALL_LIMIT = 2000;
   localparam int IN_W        = 112;
   localparam int OUT_W       = 40;
   localparam logic [23:0] PRICE_MAX = 24'hFFFFFF;

   // one market event as the block sees it
   typedef struct packed {
      tpl_pkg::op_type op;
      logic [23:0]     ask;
      logic [23:0]     bid;
      logic [1:0]      adv;
      logic [15:0]     lim;
      logic [15:0]     eid;
      logic            ok;
      logic [23:0]     price;
      logic            is_long;
   } pos_event_type;

   // one result item
   typedef struct packed {
      tpl_pkg::action_type act;
      logic [15:0]         aid;
      logic [15:0]         cnt;
      tpl_pkg::mode_type   mode;
      logic                serr;
      logic                ign;
   } pos_report_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   // ask, bid, advice, advice_limit, event_id, event_ok, event_price, event_is_long
   logic [IN_W-1:0]  req_tdata;
   // op
   logic [1:0]       req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   // action, action_id, action_contracts, mode_now, sync_error, ignored
   logic [OUT_W-1:0] rsp_tdata;
   logic             csr_valid;
   logic             csr_ready;
   logic [tpl_pkg::CSR_IDX_BITS-1:0]  csr_index;
   logic [tpl_pkg::CSR_DATA_BITS-1:0] csr_data;

   trade_position_lifecycle_fsm dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // predicted registers and position state
   logic [23:0]       cf_spread;
   logic [15:0]       cf_contracts;
   logic [7:0]        cf_timeout;
   tpl_pkg::mode_type st_mode;
   logic [23:0]       st_entry;
   logic [15:0]       st_limit;
   logic              st_retry;
   logic [15:0]       st_id;
   logic              st_has_id;
   logic              st_confirmed;
   logic [7:0]        st_wait;
   logic [15:0]       st_next_id;

   pos_report_type expected_reports[$];
   int             n_errors;
   int             idle_cycles;
   int             rsp_hold;
   bit             req_burst;
   bit             rsp_burst;

   // clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void drop_position();
      st_mode   = tpl_pkg::MODE_IDLE;
      st_entry  = '0;
      st_limit  = '0;
      st_retry  = 1'b0;
      st_has_id = 1'b0;
      st_id     = '0;
   endfunction

   function automatic pos_report_type predict_position(pos_event_type e);
      pos_report_type r;
      longint         spread, yld, mag;
      logic           go_long, held_long;
      logic [8:0]     nxt;
      r = '0;
      case (e.op)
         tpl_pkg::OP_TICK: begin
            if (!st_confirmed) begin
               drop_position();
               st_confirmed = 1'b1;
            end
            if (st_mode == tpl_pkg::MODE_LONG || st_mode == tpl_pkg::MODE_SHORT) begin
               // held position: spread gate, retry, then profit or loss limit
               go_long = (st_mode == tpl_pkg::MODE_LONG);
               spread  = longint'(e.ask) - longint'(e.bid);
               if (spread <= longint'(cf_spread)) begin
                  if (st_retry) begin
                     st_mode = go_long ? tpl_pkg::MODE_CLS_LONG : tpl_pkg::MODE_CLS_SHORT;
                     r.act   = tpl_pkg::ACT_CLOSE;
                  end else begin
                     yld = go_long ? longint'(e.bid) - longint'(st_entry)
                                   : longint'(st_entry) - longint'(e.ask);
                     mag = (yld < 0) ? -yld : yld;
                     if (mag >= longint'(st_limit)) begin
                        if (e.adv == (go_long ? tpl_pkg::ADV_LONG : tpl_pkg::ADV_SHORT)) begin
                           st_entry = go_long ? e.ask : e.bid;
                           st_limit = e.lim;
                        end else begin
                           st_mode = go_long ? tpl_pkg::MODE_CLS_LONG
                                             : tpl_pkg::MODE_CLS_SHORT;
                           r.act   = tpl_pkg::ACT_CLOSE;
                        end
                     end
                  end
               end
               if (r.act != tpl_pkg::ACT_NONE) r.aid = st_id;
            end else if (st_mode == tpl_pkg::MODE_TRY_LONG ||
                         st_mode == tpl_pkg::MODE_TRY_SHORT ||
                         st_mode == tpl_pkg::MODE_CLS_LONG ||
                         st_mode == tpl_pkg::MODE_CLS_SHORT) begin
               // pending mode: count ticks, revert on timeout
               nxt = {1'b0, st_wait} + 9'd1;
               if (nxt > {1'b0, cf_timeout}) begin
                  st_wait = '0;
                  if (st_mode == tpl_pkg::MODE_TRY_LONG ||
                      st_mode == tpl_pkg::MODE_TRY_SHORT) begin
                     st_mode   = tpl_pkg::MODE_IDLE;
                     st_entry  = '0;
                     st_retry  = 1'b0;
                     st_has_id = 1'b0;
                     st_id     = '0;
                  end else begin
                     st_mode  = (st_mode == tpl_pkg::MODE_CLS_LONG) ? tpl_pkg::MODE_LONG
                                                                    : tpl_pkg::MODE_SHORT;
                     st_retry = 1'b0;
                  end
               end else begin
                  st_wait = nxt[7:0];
               end
            end else if (e.adv == tpl_pkg::ADV_LONG || e.adv == tpl_pkg::ADV_SHORT) begin
               // idle: follow the advice with a fresh id
               go_long    = (e.adv == tpl_pkg::ADV_LONG);
               st_mode    = go_long ? tpl_pkg::MODE_TRY_LONG : tpl_pkg::MODE_TRY_SHORT;
               st_entry   = go_long ? e.ask : e.bid;
               st_id      = st_next_id;
               st_has_id  = 1'b1;
               st_next_id = st_next_id + 16'd1;
               st_retry   = 1'b0;
               st_limit   = e.lim;
               r.act      = go_long ? tpl_pkg::ACT_OPEN_LONG : tpl_pkg::ACT_OPEN_SHORT;
               r.aid      = st_id;
               r.cnt      = cf_contracts;
            end
         end
         tpl_pkg::OP_OPEN: begin
            if (st_mode != tpl_pkg::MODE_TRY_LONG && st_mode != tpl_pkg::MODE_TRY_SHORT)
               r.ign = 1'b1;
            else if (!(st_has_id && e.eid == st_id)) r.ign = 1'b1;
            else if (e.ok) begin
               st_mode  = (st_mode == tpl_pkg::MODE_TRY_LONG) ? tpl_pkg::MODE_LONG
                                                              : tpl_pkg::MODE_SHORT;
               st_entry = e.price;
            end else begin
               st_mode   = tpl_pkg::MODE_IDLE;
               st_entry  = '0;
               st_limit  = '0;
               st_has_id = 1'b0;
               st_id     = '0;
            end
         end
         tpl_pkg::OP_CLOSE: begin
            if (st_mode != tpl_pkg::MODE_CLS_LONG && st_mode != tpl_pkg::MODE_CLS_SHORT)
               r.ign = 1'b1;
            else if (!(st_has_id && e.eid == st_id)) r.ign = 1'b1;
            else if (e.ok) drop_position();
            else begin
               st_mode  = (st_mode == tpl_pkg::MODE_CLS_LONG) ? tpl_pkg::MODE_LONG
                                                              : tpl_pkg::MODE_SHORT;
               st_retry = 1'b1;
            end
         end
         default: begin
            // sync report only matters while unconfirmed
            if (!st_confirmed) begin
               if (!st_has_id) begin
                  drop_position();
                  st_confirmed = 1'b1;
               end else if (e.eid != st_id) begin
                  r.ign = 1'b1;
               end else if (st_mode != tpl_pkg::MODE_IDLE) begin
                  held_long = (st_mode == tpl_pkg::MODE_LONG ||
                               st_mode == tpl_pkg::MODE_CLS_LONG ||
                               st_mode == tpl_pkg::MODE_TRY_LONG);
                  if (held_long != e.is_long) r.serr = 1'b1;
                  else begin
                     st_mode      = held_long ? tpl_pkg::MODE_LONG : tpl_pkg::MODE_SHORT;
                     st_entry     = e.price;
                     st_retry     = 1'b0;
                     st_confirmed = 1'b1;
                  end
               end else begin
                  st_confirmed = 1'b1;
               end
            end
         end
      endcase
      r.mode = st_mode;
      return r;
   endfunction

   // ---------------------------------------------------------------- item builders

   function automatic pos_event_type random_event();
      pos_event_type e;
      e.op      = tpl_pkg::op_type'($urandom_range(0, 3));
      e.ask     = 24'($urandom_range(0, PRICE_MAX));
      e.bid     = 24'($urandom_range(0, PRICE_MAX));
      e.adv     = 2'($urandom_range(0, 3));
      e.lim     = 16'($urandom_range(0, 16'hFFFF));
      e.eid     = 16'($urandom_range(0, 16'hFFFF));
      e.ok      = 1'($urandom_range(0, 1));
      e.price   = 24'($urandom_range(0, PRICE_MAX));
      e.is_long = 1'($urandom_range(0, 1));
      return e;
   endfunction

   function automatic pos_event_type make_tick(int ask, int bid, logic [1:0] adv,
                                               logic [15:0] lim);
      pos_event_type e;
      e     = random_event();
      e.op  = tpl_pkg::OP_TICK;
      e.ask = ask[23:0];
      e.bid = bid[23:0];
      e.adv = adv;
      e.lim = lim;
      return e;
   endfunction

   function automatic pos_event_type make_notice(tpl_pkg::op_type op, logic [15:0] id,
                                                 logic ok, logic [23:0] price);
      pos_event_type e;
      e       = random_event();
      e.op    = op;
      e.eid   = id;
      e.ok    = ok;
      e.price = price;
      return e;
   endfunction

   function automatic logic [1:0] random_advice();
      case ($urandom_range(0, 5))
         0:       return tpl_pkg::ADV_NONE;
         1:       return tpl_pkg::ADV_UNDEF;
         2, 3:    return tpl_pkg::ADV_LONG;
         default: return tpl_pkg::ADV_SHORT;
      endcase
   endfunction

   function automatic logic [15:0] draw_limit();
      case ($urandom_range(0, 7))
         0:       return 16'($urandom_range(0, 16'hFFFF));
         1:       return 16'd0;
         default: return 16'($urandom_range(1, 200));
      endcase
   endfunction

   function automatic logic [23:0] random_price();
      return 24'($urandom_range(0, PRICE_MAX));
   endfunction

   // tick around a mid price with a mostly narrow, sometimes wide or crossed spread
   function automatic pos_event_type market_tick(int mid, logic [1:0] adv, logic [15:0] lim);
      int sp;
      case ($urandom_range(0, 9))
         0:       sp = 0 - int'($urandom_range(1, 50));
         1:       sp = int'($urandom_range(0, PRICE_MAX));
         2:       sp = 0;
         default: sp = int'($urandom_range(0, 30));
      endcase
      return make_tick(mid + sp / 2, mid + sp / 2 - sp, adv, lim);
   endfunction

   // mostly well-formed lifecycle traffic, some stray notices and noise
   function automatic pos_event_type next_market_event();
      pos_event_type e;
      int            mid, span, pick;
      logic [15:0]   bad_id;
      pick   = int'($urandom_range(0, 99));
      bad_id = st_id ^ (16'd1 << $urandom_range(0, 15));
      if (pick < 8) return random_event();
      case (st_mode)
         tpl_pkg::MODE_TRY_LONG, tpl_pkg::MODE_TRY_SHORT: begin
            if (pick < 62)
               e = make_notice(tpl_pkg::OP_OPEN, st_id, $urandom_range(0, 4) != 0,
                               random_price());
            else if (pick < 68)
               e = make_notice(tpl_pkg::OP_OPEN, bad_id, 1'b1, random_price());
            else if (pick < 72)
               e = make_notice(tpl_pkg::OP_CLOSE, st_id, 1'b1, random_price());
            else
               e = market_tick(int'(random_price()), random_advice(), draw_limit());
         end
         tpl_pkg::MODE_CLS_LONG, tpl_pkg::MODE_CLS_SHORT: begin
            if (pick < 62)
               e = make_notice(tpl_pkg::OP_CLOSE, st_id, $urandom_range(0, 4) > 1,
                               random_price());
            else if (pick < 68)
               e = make_notice(tpl_pkg::OP_CLOSE, bad_id, 1'b1, random_price());
            else if (pick < 72)
               e = make_notice(tpl_pkg::OP_OPEN, st_id, 1'b1, random_price());
            else
               e = market_tick(int'(random_price()), random_advice(), draw_limit());
         end
         tpl_pkg::MODE_LONG, tpl_pkg::MODE_SHORT: begin
            if (pick < 86) begin
               span = int'(st_limit) + 40;
               mid  = int'(st_entry) + int'($urandom_range(0, 2 * span)) - span;
               e    = market_tick(mid, random_advice(), draw_limit());
            end else if (pick < 90)
               e = make_notice(tpl_pkg::OP_CLOSE, st_id, 1'($urandom_range(0, 1)), st_entry);
            else if (pick < 94)
               e = make_notice(tpl_pkg::OP_OPEN, st_id, 1'($urandom_range(0, 1)), st_entry);
            else
               e = make_notice(tpl_pkg::OP_SYNC, st_id, 1'($urandom_range(0, 1)), st_entry);
         end
         default: begin
            if (pick < 90)
               e = market_tick(int'(random_price()), random_advice(), draw_limit());
            else
               e = make_notice(tpl_pkg::op_type'($urandom_range(1, 3)), st_id, 1'b1,
                               random_price());
         end
      endcase
      return e;
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send_event(input pos_event_type e);
      int gap;
      gap = req_burst ? 0 : int'($urandom_range(0, 18));
      if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, e.is_long, e.price, e.ok, e.eid, e.lim, e.adv, e.bid, e.ask};
      req_tuser  <= e.op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_reports.push_back(predict_position(e));
   endtask

   // let every outstanding result drain before touching registers
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input tpl_pkg::csr_reg_type idx, input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         tpl_pkg::CSR_SPREAD_CAP: cf_spread    = value;
         tpl_pkg::CSR_CONTRACTS:  cf_contracts = value[15:0];
         tpl_pkg::CSR_TIMEOUT:    cf_timeout   = value[7:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_registers(input logic [23:0] spread, input logic [15:0] contracts,
                                input logic [7:0] timeout);
      wait_idle();
      write_register(tpl_pkg::CSR_SPREAD_CAP, spread);
      write_register(tpl_pkg::CSR_CONTRACTS, {8'd0, contracts});
      write_register(tpl_pkg::CSR_TIMEOUT, {16'd0, timeout});
      repeat (2) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   // syncs and notices before any tick: sync without id confirms, later syncs do nothing
   task automatic test_sync_and_stray_notices();
      send_event(make_notice(tpl_pkg::OP_OPEN, 16'd0, 1'b1, 24'd100));
      send_event(make_notice(tpl_pkg::OP_CLOSE, 16'd0, 1'b1, 24'd100));
      send_event(make_notice(tpl_pkg::OP_SYNC, 16'hFFFF, 1'b1, PRICE_MAX));
      send_event(make_notice(tpl_pkg::OP_SYNC, 16'd0, 1'b0, 24'd0));
   endtask

   // open long, hold, renew, close, failed close, retry on a crossed spread
   task automatic test_long_lifecycle();
      send_event(make_tick(1000, 990, tpl_pkg::ADV_UNDEF, 16'd50));
      send_event(make_tick(1000, 990, tpl_pkg::ADV_LONG, 16'd50));
      send_event(make_notice(tpl_pkg::OP_OPEN, st_id + 16'd1, 1'b1, 24'd2000));
      send_event(make_notice(tpl_pkg::OP_CLOSE, st_id, 1'b1, 24'd2000));
      send_event(make_notice(tpl_pkg::OP_OPEN, st_id, 1'b1, 24'd2000));
      send_event(make_notice(tpl_pkg::OP_OPEN, st_id, 1'b1, 24'd2000));
      send_event(make_tick(int'(PRICE_MAX), 0, tpl_pkg::ADV_NONE, 16'd0));
      send_event(make_tick(2010, 2000, tpl_pkg::ADV_NONE, 16'd0));
      send_event(make_tick(2110, 2100, tpl_pkg::ADV_LONG, 16'd80));
      send_event(make_tick(2000, 1990, tpl_pkg::ADV_SHORT, 16'd0));
      send_event(make_notice(tpl_pkg::OP_CLOSE, st_id, 1'b0, 24'd0));
      send_event(make_tick(5, 9, tpl_pkg::ADV_NONE, 16'd0));
      send_event(make_notice(tpl_pkg::OP_CLOSE, st_id, 1'b1, 24'd0));
   endtask

   // failed open, open at the price extremes, renew and close a short
   task automatic test_short_lifecycle();
      send_event(make_tick(3000, 2990, tpl_pkg::ADV_SHORT, 16'd0));
      send_event(make_notice(tpl_pkg::OP_OPEN, st_id, 1'b0, 24'd0));
      send_event(make_tick(0, int'(PRICE_MAX), tpl_pkg::ADV_SHORT, 16'hFFFF));
      send_event(make_notice(tpl_pkg::OP_OPEN, st_id, 1'b1, PRICE_MAX));
      send_event(make_tick(0, int'(PRICE_MAX), tpl_pkg::ADV_SHORT, 16'd0));
      send_event(make_tick(0, 0, tpl_pkg::ADV_LONG, 16'd0));
      send_event(make_notice(tpl_pkg::OP_CLOSE, st_id, 1'b1, 24'd0));
   endtask

   // pending modes that run out of ticks at short timeouts
   task automatic test_pending_timeouts();
      set_registers(24'd10000000, 16'd7, 8'd0);
      send_event(make_tick(500, 490, tpl_pkg::ADV_LONG, 16'd0));
      send_event(make_tick(500, 490, tpl_pkg::ADV_NONE, 16'd0));
      send_event(make_tick(600, 590, tpl_pkg::ADV_SHORT, 16'd0));
      send_event(make_notice(tpl_pkg::OP_OPEN, st_id, 1'b1, 24'd600));
      send_event(make_tick(610, 600, tpl_pkg::ADV_NONE, 16'd0));
      send_event(make_tick(610, 600, tpl_pkg::ADV_NONE, 16'd0));
      set_registers(24'd10000000, 16'd7, 8'd2);
      repeat (4) send_event(make_tick(610, 600, tpl_pkg::ADV_NONE, 16'd0));
      send_event(make_notice(tpl_pkg::OP_CLOSE, st_id, 1'b1, 24'd0));
   endtask

   // unused register index must leave the registers alone
   task automatic test_unused_register();
      wait_idle();
      write_register(tpl_pkg::CSR_UNUSED, random_price());
   endtask

   task automatic test_random_phase(input int count, input logic [23:0] spread,
                                    input logic [15:0] contracts, input logic [7:0] timeout);
      set_registers(spread, contracts, timeout);
      repeat (count) send_event(next_market_event());
   endtask

   // ---------------------------------------------------------------- result side

   function automatic void check_report(logic [OUT_W-1:0] d);
      pos_report_type got, want;
      got.act  = tpl_pkg::action_type'(d[1:0]);
      got.aid  = d[17:2];
      got.cnt  = d[33:18];
      got.mode = tpl_pkg::mode_type'(d[36:34]);
      got.serr = d[37];
      got.ign  = d[38];
      if (expected_reports.size() == 0) begin
         if (n_errors < 10)
            $display("unexpected result item: act=%0d id=%0h cnt=%0h mode=%0d serr=%b ign=%b",
                     got.act, got.aid, got.cnt, got.mode, got.serr, got.ign);
         n_errors++;
         return;
      end
      want = expected_reports.pop_front();
      if (got.act !== want.act || got.aid !== want.aid || got.cnt !== want.cnt ||
          got.mode !== want.mode || got.serr !== want.serr || got.ign !== want.ign) begin
         if (n_errors < 10)
            $display("mismatch: exp act=%0d id=%0h cnt=%0h mode=%0d serr=%b ign=%b, ",
                     want.act, want.aid, want.cnt, want.mode, want.serr, want.ign,
                     "got act=%0d id=%0h cnt=%0h mode=%0d serr=%b ign=%b",
                     got.act, got.aid, got.cnt, got.mode, got.serr, got.ign);
         n_errors++;
      end
   endfunction

   // accept results with random stalls
   always @(posedge clock) begin : rsp_side
      int stall;
      if (reset) begin
         rsp_tready <= 1'b1;
         rsp_hold   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         check_report(rsp_tdata);
         stall = rsp_burst ? 0 : int'($urandom_range(0, 18));
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
         rsp_tready <= (stall == 0);
         rsp_hold   <= stall;
      end else if (!rsp_tready) begin
         if (rsp_hold <= 1) rsp_tready <= 1'b1;
         rsp_hold <= rsp_hold - 1;
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("trade_position_lifecycle_fsm_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tuser    <= tpl_pkg::OP_TICK;
      csr_valid    <= 1'b0;
      csr_index    <= tpl_pkg::CSR_SPREAD_CAP;
      csr_data     <= '0;
      n_errors     = 0;
      idle_cycles  = 0;
      req_burst    = 1'b0;
      rsp_burst    = 1'b0;
      cf_spread    = tpl_pkg::SPREAD_CAP_RST;
      cf_contracts = tpl_pkg::CONTRACTS_RST;
      cf_timeout   = tpl_pkg::TIMEOUT_RST;
      drop_position();
      st_confirmed = 1'b0;
      st_wait      = '0;
      st_next_id   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_sync_and_stray_notices();
      test_long_lifecycle();
      test_short_lifecycle();
      test_pending_timeouts();
      test_unused_register();

      test_random_phase(250, tpl_pkg::SPREAD_CAP_RST, tpl_pkg::CONTRACTS_RST,
                        tpl_pkg::TIMEOUT_RST);
      test_random_phase(150, 24'd0, 16'hFFFF, 8'd0);
      test_random_phase(200, PRICE_MAX, 16'($urandom_range(1, 16'hFFFF)), 8'hFF);
      test_random_phase(200, 24'($urandom_range(0, 64)), 16'($urandom_range(1, 16'hFFFF)),
                        8'($urandom_range(1, 5)));
      test_random_phase(200, random_price(), 16'($urandom_range(1, 16'hFFFF)),
                        8'($urandom_range(0, 12)));

      wait_idle();
      repeat (8) @(posedge clock);
      if (n_errors == 0) $display("trade_position_lifecycle_fsm_tb: done, clean");
      else $display("trade_position_lifecycle_fsm_tb: done, errors");
      $finish;
   end

endmodule
